@@ rtl/mwa_pkg.sv @@
// Shared types and constants for the multichannel window averager.
// No dependencies; imported by every module of the block.
`default_nettype none

package mwa_pkg;

    localparam int WINDOW_SAMPLES = 8;
    localparam int MAX_CHANNELS   = 8;
    localparam int DEF_CHANNELS   = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int SLOT_W    = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int CNT_W     = $clog2(WINDOW_SAMPLES + 1);
    localparam int ACC_W     = SAMPLE_W + 1 + $clog2(WINDOW_SAMPLES);
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REDUCE = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_REDUCE,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        logic                       kind;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]          out_channel;
        logic signed [SAMPLE_W-1:0] average;
        logic [COUNT_W-1:0]         sample_count;
    } t_out;

    typedef struct packed {
        t_op                        op;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

`default_nettype wire

@@ rtl/mwa_front.sv @@
// Front end: accepts items, classifies them, and queues commands for the back end.
// Depends on mwa_pkg.
`default_nettype none

module mwa_front #(
    parameter int CHANNELS = mwa_pkg::DEF_CHANNELS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mwa_pkg::t_in  i_item,
    output mwa_pkg::t_head     o_head,
    input  wire logic          i_pop
);
    import mwa_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic w_accept;
    logic w_in_range;
    logic w_keep;
    logic w_enq;
    logic w_deq;
    t_cmd w_cmd;

    assign o_stall    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (int'(i_item.channel) < CHANNELS);

    // out-of-range pushes are dropped, out-of-range reduces still answer
    always_comb begin
        w_cmd.channel = i_item.channel;
        w_cmd.sample  = i_item.sample;
        if (i_item.kind == KIND_PUSH) begin
            w_cmd.op = OP_PUSH;
        end else if (w_in_range) begin
            w_cmd.op = OP_REDUCE;
        end else begin
            w_cmd.op = OP_EMPTY;
        end
        w_keep = (i_item.kind == KIND_REDUCE) || w_in_range;
    end

    assign w_enq = w_accept && w_keep;
    assign w_deq = o_head.valid && i_pop;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wp <= (int'(r_wp) == QUEUE_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= (int'(r_rp) == QUEUE_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_enq && w_deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !w_deq)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= QUEUE_DEPTH)
        else $error("queue count overflow");

    a_dropped_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_keep |=> r_cnt == $past(r_cnt) - QCNT_W'($past(w_deq)))
        else $error("dropped push changed queue fill");

endmodule

`default_nettype wire

@@ rtl/mwa_back.sv @@
// Back end: per-channel windows, sample memory, summing loop and serial divider.
// Depends on mwa_pkg; fed by mwa_front.
`default_nettype none

module mwa_back #(
    parameter int CHANNELS = mwa_pkg::DEF_CHANNELS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mwa_pkg::t_head i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output mwa_pkg::t_out      o_item
);
    import mwa_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH    = CHANNELS * WINDOW_SAMPLES;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W    = $clog2(ACC_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    t_state              r_st;
    logic [CNT_W-1:0]    r_fill [CHANNELS];
    logic [SLOT_W-1:0]   r_old  [CHANNELS];
    logic [CHAN_W-1:0]   r_ch;
    logic [CNT_W-1:0]    r_n;
    logic [SLOT_W-1:0]   r_first;
    logic [CNT_W-1:0]    r_idx;
    logic                r_rd_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic                r_neg;
    logic [ACC_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [BIT_W-1:0]    r_bit;
    logic                r_out_valid;
    t_out                r_out;

    logic [CH_IDX_W-1:0] w_qch;
    logic [CNT_W-1:0]    w_qfill;
    logic [SLOT_W-1:0]   w_qold;
    logic [SLOT_W-1:0]   w_wslot;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [SLOT_W-1:0]   w_rslot;
    logic [ADDR_W-1:0]   w_raddr;
    logic                w_issue;
    logic [CNT_W:0]      w_rem_sh;
    logic                w_qbit;
    logic [ACC_W-1:0]    w_avg;
    logic                w_out_free;

    function automatic logic [SLOT_W-1:0] wrap_slot(input int a, input int b);
        int s;
        s = a + b;
        if (s >= WINDOW_SAMPLES) begin
            s = s - WINDOW_SAMPLES;
        end
        return SLOT_W'(s);
    endfunction

    assign w_qch   = i_head.cmd.channel[CH_IDX_W-1:0];
    assign w_qfill = r_fill[w_qch];
    assign w_qold  = r_old[w_qch];
    assign o_pop   = (r_st == S_IDLE) && i_head.valid;
    assign w_we    = o_pop && (i_head.cmd.op == OP_PUSH);
    assign w_wslot = (int'(w_qfill) < WINDOW_SAMPLES) ?
                     wrap_slot(int'(w_qold), int'(w_qfill)) : w_qold;
    assign w_waddr = ADDR_W'(int'(w_qch) * WINDOW_SAMPLES + int'(w_wslot));

    assign w_issue = (r_st == S_SUM) && (r_idx < r_n);
    assign w_rslot = wrap_slot(int'(r_first), int'(r_idx));
    assign w_raddr = ADDR_W'(int'(r_ch[CH_IDX_W-1:0]) * WINDOW_SAMPLES + int'(w_rslot));

    assign w_rem_sh = {r_rem, r_quo[ACC_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_n});
    assign w_avg    = r_neg ? (~r_quo + ACC_W'(1)) : r_quo;
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_head.cmd.sample;
        end
        r_rd_data <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c] <= '0;
                r_old[c]  <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall && r_st != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= w_issue;
            case (r_st)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_ch    <= i_head.cmd.channel;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_quo   <= '0;
                        r_neg   <= 1'b0;
                        r_n     <= '0;
                        r_first <= w_qold;
                        case (i_head.cmd.op)
                            OP_PUSH: begin
                                if (int'(w_qfill) < WINDOW_SAMPLES) begin
                                    r_fill[w_qch] <= w_qfill + 1'b1;
                                end else begin
                                    r_old[w_qch] <= wrap_slot(int'(w_qold), 1);
                                end
                            end
                            OP_REDUCE: begin
                                r_n           <= w_qfill;
                                r_fill[w_qch] <= '0;
                                r_old[w_qch]  <= '0;
                                r_st          <= (w_qfill == '0) ? S_DONE : S_SUM;
                            end
                            default: begin
                                r_st <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_acc <= r_acc + ACC_W'($signed(r_rd_data));
                    end else if (!w_issue) begin
                        r_neg <= r_acc[ACC_W-1];
                        r_quo <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
                        r_rem <= '0;
                        r_bit <= BIT_W'(ACC_W);
                        r_st  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_qbit ? CNT_W'(w_rem_sh - {1'b0, r_n}) : CNT_W'(w_rem_sh);
                    r_quo <= {r_quo[ACC_W-2:0], w_qbit};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == BIT_W'(1)) begin
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.out_channel  <= r_ch;
                        r_out.average      <= w_avg[SAMPLE_W-1:0];
                        r_out.sample_count <= COUNT_W'(r_n);
                        r_out_valid        <= 1'b1;
                        r_st               <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_st == S_IDLE)
        else $error("memory write outside idle");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SUM |-> (r_idx <= r_n) && (r_n != '0))
        else $error("summing index out of range");

    a_read_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_st == S_SUM)
        else $error("read data arrived outside summing");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_DONE && w_out_free |=> o_valid && r_st == S_IDLE)
        else $error("result not presented");

endmodule

`default_nettype wire

@@ rtl/multichannel_window_averager.sv @@
// Top level of the multichannel window averager: front end, command queue and back end.
// Depends on mwa_pkg, mwa_front and mwa_back.
//
// Keeps a window of the last WINDOW_SAMPLES signed samples for each of CHANNELS channels.
// A push item is one memory write in the back end. A reduce item on n held samples
// takes one memory read per sample, then a bit-serial divide of ACC_W (20) steps.
// A two-entry command queue sits in front, so the input takes up to two more items
// while a reduce runs and stalls after that; the result register holds one average
// while the next item runs.
`default_nettype none

module multichannel_window_averager #(
    parameter int CHANNELS = mwa_pkg::DEF_CHANNELS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mwa_pkg::t_in  i_item,
    output logic               o_valid,
    input  wire logic          i_stall,
    output mwa_pkg::t_out      o_item
);
    import mwa_pkg::*;

    t_head w_head;
    logic  w_pop;

    mwa_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    mwa_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire
